@@ hdl/lpr_pkg.sv @@
// Package for the line pixel rasterizer: widths and the queue entry type shared by
// the front, queue and back modules, and the depth of the queue.
// No dependencies.
package lpr_pkg;

  // Coordinate width of the walk; positions wrap in this many bits
  localparam int CoordBits = 8;
  // Error term width: holds 2*minor - major and the sums along the walk
  localparam int ErrBits   = CoordBits + 3;
  // Width of the colour and the external coordinate fields
  localparam int ColourBits = 12;
  localparam int PixBits    = 8;
  // Entries in the command queue between front and back
  localparam int QDepth     = 2;
  localparam int QPtrBits   = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntBits   = $clog2(QDepth + 1);

  typedef logic [CoordBits-1:0]        coord_t;
  typedef logic signed [CoordBits:0]   delta_t;
  typedef logic signed [ErrBits-1:0]   err_t;
  typedef logic [ColourBits-1:0]       colour_t;

  // One classified command: a tick, or a load with its walk set up
  typedef struct packed {
    logic    is_load;
    colour_t colour;
    logic    swapped;
    logic    major_desc;
    logic    minor_desc;
    coord_t  major_pos;
    coord_t  major_end;
    coord_t  minor_pos;
    err_t    err;
    err_t    straight_inc;
    err_t    diag_inc;
  } cmd_t;

endpackage

@@ hdl/lpr_front.sv @@
// Front end of the line pixel rasterizer: classifies each input item and
// works out the axis swap, step signs and error increments of a load.
// Depends on lpr_pkg.
module lpr_front (
  input  logic                         mode_i,
  input  logic [lpr_pkg::ColourBits-1:0] line_colour_i,
  input  logic [lpr_pkg::PixBits-1:0]  start_x_i,
  input  logic [lpr_pkg::PixBits-1:0]  start_y_i,
  input  logic [lpr_pkg::PixBits-1:0]  end_x_i,
  input  logic [lpr_pkg::PixBits-1:0]  end_y_i,
  output lpr_pkg::cmd_t                cmd_o
);

  lpr_pkg::coord_t x0, y0, x1, y1;
  lpr_pkg::delta_t dx, dy;
  lpr_pkg::coord_t adx, ady, da, db;
  logic            swap;
  lpr_pkg::err_t   straight;

  // Take the endpoints modulo the coordinate width
  assign x0 = lpr_pkg::CoordBits'(start_x_i);
  assign y0 = lpr_pkg::CoordBits'(start_y_i);
  assign x1 = lpr_pkg::CoordBits'(end_x_i);
  assign y1 = lpr_pkg::CoordBits'(end_y_i);

  // Signed deltas and their magnitudes
  assign dx  = lpr_pkg::delta_t'({1'b0, x1}) - lpr_pkg::delta_t'({1'b0, x0});
  assign dy  = lpr_pkg::delta_t'({1'b0, y1}) - lpr_pkg::delta_t'({1'b0, y0});
  assign adx = dx[lpr_pkg::CoordBits] ? lpr_pkg::CoordBits'(-dx) : lpr_pkg::CoordBits'(dx);
  assign ady = dy[lpr_pkg::CoordBits] ? lpr_pkg::CoordBits'(-dy) : lpr_pkg::CoordBits'(dy);

  // A tie counts as steep: the row becomes the major axis
  assign swap = (ady >= adx);
  assign da   = swap ? ady : adx;
  assign db   = swap ? adx : ady;

  assign straight = lpr_pkg::err_t'({db, 1'b0});

  // Build the command entry
  always_comb begin
    cmd_o.is_load      = ~mode_i;
    cmd_o.colour       = line_colour_i;
    cmd_o.swapped      = swap;
    cmd_o.major_desc   = swap ? dy[lpr_pkg::CoordBits] : dx[lpr_pkg::CoordBits];
    cmd_o.minor_desc   = swap ? dx[lpr_pkg::CoordBits] : dy[lpr_pkg::CoordBits];
    cmd_o.major_pos    = swap ? y0 : x0;
    cmd_o.major_end    = swap ? y1 : x1;
    cmd_o.minor_pos    = swap ? x0 : y0;
    cmd_o.straight_inc = straight;
    cmd_o.diag_inc     = straight - lpr_pkg::err_t'({da, 1'b0});
    cmd_o.err          = straight - lpr_pkg::err_t'(da);
  end

endmodule

@@ hdl/lpr_queue.sv @@
// Short command queue between the front and back of the rasterizer.
// Depends on lpr_pkg.
module lpr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lpr_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output lpr_pkg::cmd_t head_cmd_o
);

  lpr_pkg::cmd_t                  mem_q [lpr_pkg::QDepth];
  logic [lpr_pkg::QPtrBits-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [lpr_pkg::QCntBits-1:0]   count_q, count_d;
  logic                           do_push, do_pop;

  assign full_o       = (count_q == lpr_pkg::QCntBits'(lpr_pkg::QDepth));
  assign head_valid_o = (count_q != '0);
  assign head_cmd_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == lpr_pkg::QPtrBits'(lpr_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == lpr_pkg::QPtrBits'(lpr_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ hdl/lpr_back.sv @@
// Back end of the rasterizer: holds the line walk, executes queued loads and
// ticks, and drives the pixel output register.
// Depends on lpr_pkg.
module lpr_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           head_valid_i,
  input  lpr_pkg::cmd_t                  head_cmd_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [lpr_pkg::PixBits-1:0]    pixel_x_o,
  output logic [lpr_pkg::PixBits-1:0]    pixel_y_o,
  output logic [lpr_pkg::ColourBits-1:0] pixel_colour_o,
  output logic                           last_pixel_o
);

  // Walk state
  logic             active_q, active_d;
  lpr_pkg::coord_t  major_q, major_d, major_end_q, major_end_d, minor_q, minor_d;
  lpr_pkg::err_t    err_q, err_d, straight_q, straight_d, diag_q, diag_d;
  logic             major_desc_q, major_desc_d, minor_desc_q, minor_desc_d;
  logic             swapped_q, swapped_d;
  lpr_pkg::colour_t colour_q, colour_d;

  // Output register
  logic                           out_valid_q, out_valid_d;
  logic [lpr_pkg::PixBits-1:0]    px_q, px_d, py_q, py_d;
  lpr_pkg::colour_t               ocol_q, ocol_d;
  logic                           last_q, last_d;

  lpr_pkg::coord_t next_major, next_minor;
  logic            is_last, err_pos, emit;

  // Pop whenever the output register is free or is being drained
  assign pop_o = head_valid_i && (!out_valid_q || !out_stall_i);
  assign emit  = pop_o && !head_cmd_i.is_load && active_q;

  assign next_major = major_desc_q ? major_q - 1'b1 : major_q + 1'b1;
  assign next_minor = minor_desc_q ? minor_q - 1'b1 : minor_q + 1'b1;
  assign is_last    = (next_major == major_end_q);
  assign err_pos    = !err_q[lpr_pkg::ErrBits-1] && (err_q != '0);

  always_comb begin
    active_d     = active_q;
    major_d      = major_q;
    major_end_d  = major_end_q;
    minor_d      = minor_q;
    err_d        = err_q;
    straight_d   = straight_q;
    diag_d       = diag_q;
    major_desc_d = major_desc_q;
    minor_desc_d = minor_desc_q;
    swapped_d    = swapped_q;
    colour_d     = colour_q;
    out_valid_d  = out_valid_q && out_stall_i;
    px_d         = px_q;
    py_d         = py_q;
    ocol_d       = ocol_q;
    last_d       = last_q;
    if (pop_o && head_cmd_i.is_load) begin
      // Replace the walk with the new line
      active_d     = (head_cmd_i.major_pos != head_cmd_i.major_end);
      major_d      = head_cmd_i.major_pos;
      major_end_d  = head_cmd_i.major_end;
      minor_d      = head_cmd_i.minor_pos;
      err_d        = head_cmd_i.err;
      straight_d   = head_cmd_i.straight_inc;
      diag_d       = head_cmd_i.diag_inc;
      major_desc_d = head_cmd_i.major_desc;
      minor_desc_d = head_cmd_i.minor_desc;
      swapped_d    = head_cmd_i.swapped;
      colour_d     = head_cmd_i.colour;
    end else if (emit) begin
      // Emit the current pixel and advance one step on the major axis
      out_valid_d = 1'b1;
      px_d        = lpr_pkg::PixBits'(swapped_q ? minor_q : major_q);
      py_d        = lpr_pkg::PixBits'(swapped_q ? major_q : minor_q);
      ocol_d      = colour_q;
      last_d      = is_last;
      major_d     = next_major;
      if (err_pos) begin
        err_d   = err_q + diag_q;
        minor_d = next_minor;
      end else begin
        err_d = err_q + straight_q;
      end
      if (is_last) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      major_q      <= '0;
      major_end_q  <= '0;
      minor_q      <= '0;
      err_q        <= '0;
      straight_q   <= '0;
      diag_q       <= '0;
      major_desc_q <= 1'b0;
      minor_desc_q <= 1'b0;
      swapped_q    <= 1'b0;
      colour_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      active_q     <= active_d;
      major_q      <= major_d;
      major_end_q  <= major_end_d;
      minor_q      <= minor_d;
      err_q        <= err_d;
      straight_q   <= straight_d;
      diag_q       <= diag_d;
      major_desc_q <= major_desc_d;
      minor_desc_q <= minor_desc_d;
      swapped_q    <= swapped_d;
      colour_q     <= colour_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Hold the pixel payload until it transfers
  always_ff @(posedge clk_i) begin
    px_q   <= px_d;
    py_q   <= py_d;
    ocol_q <= ocol_d;
    last_q <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_x_o      = px_q;
  assign pixel_y_o      = py_q;
  assign pixel_colour_o = ocol_q;
  assign last_pixel_o   = last_q;

endmodule

@@ hdl/line_pixel_rasterizer_top.sv @@
// Line pixel rasterizer: a load sets up a Bresenham walk; while it is active, each tick
// emits one pixel. A tick passes through a queue entry and then the output register;
// one item transfers per cycle while the input is not stalled. The input stalls only
// once both queue entries wait behind a held pixel; it frees once the held pixel
// transfers and an entry is popped. Reset (rst_ni low, asynchronous) empties the queue
// and output and clears the walk. Depends on lpr_pkg, lpr_front, lpr_queue, lpr_back.
module line_pixel_rasterizer_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           mode_i,
  input  logic [lpr_pkg::ColourBits-1:0] line_colour_i,
  input  logic [lpr_pkg::PixBits-1:0]    start_x_i,
  input  logic [lpr_pkg::PixBits-1:0]    start_y_i,
  input  logic [lpr_pkg::PixBits-1:0]    end_x_i,
  input  logic [lpr_pkg::PixBits-1:0]    end_y_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [lpr_pkg::PixBits-1:0]    pixel_x_o,
  output logic [lpr_pkg::PixBits-1:0]    pixel_y_o,
  output logic [lpr_pkg::ColourBits-1:0] pixel_colour_o,
  output logic                           last_pixel_o
);

  lpr_pkg::cmd_t front_cmd, head_cmd;
  logic          q_full, head_valid, pop;

  // Classify and set up
  lpr_front u_front (
    .mode_i        (mode_i),
    .line_colour_i (line_colour_i),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .cmd_o         (front_cmd)
  );

  // Decouple front and back
  lpr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_valid_i),
    .push_cmd_i   (front_cmd),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd)
  );

  assign in_stall_o = q_full;

  // Walk the line and drive the pixel output
  lpr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_cmd_i     (head_cmd),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .pixel_colour_o (pixel_colour_o),
    .last_pixel_o   (last_pixel_o)
  );

endmodule

@@ hdl/lpr_checker.sv @@
// Port-level checks for the line pixel rasterizer, bound to its top level.
// Depends on lpr_pkg and line_pixel_rasterizer_top.
module lpr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           mode_i,
  input logic [lpr_pkg::ColourBits-1:0] line_colour_i,
  input logic [lpr_pkg::PixBits-1:0]    start_x_i,
  input logic [lpr_pkg::PixBits-1:0]    start_y_i,
  input logic [lpr_pkg::PixBits-1:0]    end_x_i,
  input logic [lpr_pkg::PixBits-1:0]    end_y_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [lpr_pkg::PixBits-1:0]    pixel_x_o,
  input logic [lpr_pkg::PixBits-1:0]    pixel_y_o,
  input logic [lpr_pkg::ColourBits-1:0] pixel_colour_o,
  input logic                           last_pixel_o
);

  // Hold a stalled input item and its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(mode_i) &&
      $stable(line_colour_i) && $stable(start_x_i) && $stable(start_y_i) &&
      $stable(end_x_i) && $stable(end_y_i))
    else $error("stalled input item changed");

  // Hold a stalled pixel and its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_x_o) &&
      $stable(pixel_y_o) && $stable(pixel_colour_o) && $stable(last_pixel_o))
    else $error("stalled pixel changed");

  // Leave reset with no pixel pending
  assert property (@(posedge clk_i) $past(!rst_ni) && rst_ni |-> !out_valid_o)
    else $error("pixel valid right after reset");

  // Keep the input free whenever no pixel was held by a stall in the previous cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && $past(!(out_valid_o && out_stall_i)) |-> !in_stall_o)
    else $error("input stalled although the back end was free");

endmodule

bind line_pixel_rasterizer_top lpr_checker u_lpr_checker (.*);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for line_pixel_rasterizer_top: a queue-fed driver, a stalling receiver and a
// monitor that checks every pixel against an in-bench Bresenham walk predictor.
// Depends on lpr_pkg and line_pixel_rasterizer_top.
module testbench;

  typedef logic [lpr_pkg::PixBits-1:0] pix_t;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_TICK = 1'b1
  } mode_e;

  typedef struct {
    mode_e            mode;
    lpr_pkg::colour_t colour;
    pix_t             sx;
    pix_t             sy;
    pix_t             ex;
    pix_t             ey;
  } line_cmd_t;

  typedef struct {
    pix_t             x;
    pix_t             y;
    lpr_pkg::colour_t colour;
    logic             last;
  } pixel_t;

  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 64;

  // Clock, reset and block ports
  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic             mode_i = 1'b0;
  lpr_pkg::colour_t line_colour_i = '0;
  pix_t             start_x_i = '0;
  pix_t             start_y_i = '0;
  pix_t             end_x_i = '0;
  pix_t             end_y_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  pix_t             pixel_x_o;
  pix_t             pixel_y_o;
  lpr_pkg::colour_t pixel_colour_o;
  logic             last_pixel_o;

  // Stimulus and expected pixels
  line_cmd_t cmd_queue[$];
  line_cmd_t drive_cmd;
  pixel_t    pixel_queue[$];
  pixel_t    got_pixel;
  int        phase = 0;
  int        send_idle_pct = 33;
  int        recv_idle_pct = 62;
  int        phase_items;
  int        hold_left;
  logic      hold_done;
  int        quiet_cycles = 0;
  int        error_count = 0;
  int        items_sent = 0;
  int        lines_loaded = 0;
  int        pixels_seen = 0;

  // Predicted walk state
  logic             walk_active = 1'b0;
  pix_t             walk_major = '0;
  pix_t             walk_major_end = '0;
  pix_t             walk_minor = '0;
  int               walk_err = 0;
  int               walk_straight = 0;
  int               walk_diag = 0;
  logic             walk_major_down = 1'b0;
  logic             walk_minor_down = 1'b0;
  logic             walk_swapped = 1'b0;
  lpr_pkg::colour_t walk_colour = '0;

  line_pixel_rasterizer_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .line_colour_i  (line_colour_i),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .end_x_i        (end_x_i),
    .end_y_i        (end_y_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .pixel_colour_o (pixel_colour_o),
    .last_pixel_o   (last_pixel_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int span(input pix_t a, input pix_t b);
    int d;
    d = int'(b) - int'(a);
    return (d < 0) ? -d : d;
  endfunction

  // Advance the predicted walk by one transferred item; queue the pixel it yields
  task automatic rasterize_item(input mode_e mode, input lpr_pkg::colour_t colour,
                                input pix_t sx, input pix_t sy, input pix_t ex, input pix_t ey);
    int   dx;
    int   dy;
    int   da;
    int   db;
    pix_t nxt;
    pixel_t pix;
    if (mode == MODE_LOAD) begin
      dx = int'(ex) - int'(sx);
      dy = int'(ey) - int'(sy);
      walk_colour = colour;
      // a tie in the deltas counts as steep
      walk_swapped = (span(sy, ey) >= span(sx, ex));
      if (walk_swapped) begin
        walk_major = sy;
        walk_major_end = ey;
        walk_minor = sx;
        da = dy;
        db = dx;
      end else begin
        walk_major = sx;
        walk_major_end = ex;
        walk_minor = sy;
        da = dx;
        db = dy;
      end
      walk_major_down = (da < 0);
      walk_minor_down = (db < 0);
      if (da < 0) da = -da;
      if (db < 0) db = -db;
      walk_straight = 2 * db;
      walk_diag = 2 * db - 2 * da;
      walk_err = 2 * db - da;
      walk_active = (walk_major != walk_major_end);
      lines_loaded++;
    end else if (walk_active) begin
      pix.x = walk_swapped ? walk_minor : walk_major;
      pix.y = walk_swapped ? walk_major : walk_minor;
      pix.colour = walk_colour;
      nxt = walk_major_down ? walk_major - 8'd1 : walk_major + 8'd1;
      pix.last = (nxt == walk_major_end);
      pixel_queue.push_back(pix);
      if (walk_err > 0) begin
        walk_err += walk_diag;
        walk_minor = walk_minor_down ? walk_minor - 8'd1 : walk_minor + 8'd1;
      end else begin
        walk_err += walk_straight;
      end
      walk_major = nxt;
      if (pix.last) walk_active = 1'b0;
    end
  endtask

  // Driver: present queued items, idle at random, hold payload while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      mode_i <= 1'b0;
      line_colour_i <= '0;
      start_x_i <= '0;
      start_y_i <= '0;
      end_x_i <= '0;
      end_y_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        rasterize_item(mode_e'(mode_i), line_colour_i, start_x_i, start_y_i, end_x_i, end_y_i);
        items_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drive_cmd = cmd_queue.pop_front();
          mode_i <= drive_cmd.mode;
          line_colour_i <= drive_cmd.colour;
          start_x_i <= drive_cmd.sx;
          start_y_i <= drive_cmd.sy;
          end_x_i <= drive_cmd.ex;
          end_y_i <= drive_cmd.ey;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall at random; once, in the last phase, hold off for a long stretch
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (phase == 2 && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Monitor: compare each pixel transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      pixels_seen++;
      if (pixel_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel (%0d,%0d)", pixel_x_o, pixel_y_o));
      end else begin
        got_pixel = pixel_queue.pop_front();
        if (pixel_x_o !== got_pixel.x)
          report_mismatch($sformatf("pixel_x %0d, want %0d", pixel_x_o, got_pixel.x));
        if (pixel_y_o !== got_pixel.y)
          report_mismatch($sformatf("pixel_y %0d, want %0d", pixel_y_o, got_pixel.y));
        if (pixel_colour_o !== got_pixel.colour)
          report_mismatch($sformatf("pixel_colour %h, want %h", pixel_colour_o,
                                    got_pixel.colour));
        if (last_pixel_o !== got_pixel.last)
          report_mismatch($sformatf("last_pixel %b, want %b", last_pixel_o, got_pixel.last));
      end
    end
  end

  // Watchdog: end the run after a long stretch without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("Timeout after %0d quiet cycles", quiet_cycles);
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_cmd(input mode_e mode, input lpr_pkg::colour_t colour,
                          input pix_t sx, input pix_t sy, input pix_t ex, input pix_t ey);
    line_cmd_t c;
    c.mode = mode;
    c.colour = colour;
    c.sx = sx;
    c.sy = sy;
    c.ex = ex;
    c.ey = ey;
    cmd_queue.push_back(c);
    phase_items++;
  endtask

  // Ticks carry random, ignored payload so every field bit toggles
  task automatic push_ticks(input int n);
    repeat (n) push_cmd(MODE_TICK, lpr_pkg::colour_t'($urandom), pix_t'($urandom),
                        pix_t'($urandom), pix_t'($urandom), pix_t'($urandom));
  endtask

  function automatic pix_t pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return pix_t'($urandom_range(0, 255));
  endfunction

  function automatic pix_t near_coord(input pix_t c);
    int v;
    v = int'(c) + $urandom_range(0, 20) - 10;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return pix_t'(v);
  endfunction

  // Queue a load and its ticks; short lines mostly, now and then a full-range one
  task automatic queue_line(input bit full_range);
    pix_t sx;
    pix_t sy;
    pix_t ex;
    pix_t ey;
    int   steps;
    int   ticks;
    sx = pick_coord();
    sy = pick_coord();
    if (full_range) begin
      ex = pix_t'($urandom_range(0, 255));
      ey = pix_t'($urandom_range(0, 255));
    end else if ($urandom_range(0, 19) == 0) begin
      ex = sx;
      ey = sy;
    end else begin
      ex = near_coord(sx);
      ey = near_coord(sy);
    end
    steps = (span(sx, ex) > span(sy, ey)) ? span(sx, ex) : span(sy, ey);
    // cut some lines short so the next load replaces them
    if (!full_range && $urandom_range(0, 6) == 0) ticks = $urandom_range(0, steps);
    else ticks = steps + $urandom_range(0, 2);
    push_cmd(MODE_LOAD, lpr_pkg::colour_t'($urandom), sx, sy, ex, ey);
    push_ticks(ticks);
  endtask

  task automatic queue_random(input int n);
    int r;
    phase_items = 0;
    while (phase_items < n) begin
      r = $urandom_range(0, 99);
      if (r < 75) queue_line(1'b0);
      else if (r < 80) queue_line(1'b1);
      else if (r < 90) push_ticks(1);
      else push_cmd(MODE_LOAD, lpr_pkg::colour_t'($urandom), pix_t'($urandom),
                    pix_t'($urandom), pix_t'($urandom), pix_t'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (cmd_queue.size() > 0 || in_valid_i) @(negedge clk_i);
  endtask

  // Sequence: reset, directed lines, then three random phases with changing idling
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // tick with nothing loaded, then a degenerate line
    push_ticks(1);
    push_cmd(MODE_LOAD, 12'hFFF, 8'd255, 8'd255, 8'd255, 8'd255);
    push_ticks(1);
    // shallow ascending line, one tick past its end
    push_cmd(MODE_LOAD, 12'h000, 8'd0, 8'd0, 8'd3, 8'd1);
    push_ticks(4);
    // long steep line abandoned by a new load
    push_cmd(MODE_LOAD, 12'h123, 8'd255, 8'd0, 8'd253, 8'd255);
    push_ticks(2);
    // steep, rows descending from the bottom edge
    push_cmd(MODE_LOAD, 12'hA5A, 8'd0, 8'd255, 8'd2, 8'd252);
    push_ticks(3);
    // equal deltas take the steep path
    push_cmd(MODE_LOAD, 12'h5A5, 8'd10, 8'd10, 8'd12, 8'd8);
    push_ticks(2);
    // shallow, columns descending from the right edge
    push_cmd(MODE_LOAD, 12'hFFF, 8'd255, 8'd128, 8'd250, 8'd130);
    push_ticks(5);

    queue_random(145);
    wait_drained();

    phase = 1;
    send_idle_pct = 62;
    recv_idle_pct = 33;
    queue_random(145);
    wait_drained();

    phase = 2;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(145);
    wait_drained();

    while (pixel_queue.size() > 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("Sent %0d items (%0d loads), checked %0d pixels over three idling phases",
             items_sent, lines_loaded, pixels_seen);
    $display("with a long output hold-off; %0d mismatches", error_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/lpr_pkg.sv
hdl/lpr_front.sv
hdl/lpr_queue.sv
hdl/lpr_back.sv
hdl/line_pixel_rasterizer_top.sv
hdl/lpr_checker.sv
tb/sv/testbench.sv
